// File: hdl/lhs_pkg.sv
// ----------------------------------------------------------------------------
// Loop health supervisor package
// Shared widths, codes, reset values and the structs passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package lhs_pkg;

    localparam int unsigned WORD_W       = 32;
    localparam int unsigned NUM_TOTALS   = 5;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned TICKS_PER_MS = 72000;

    localparam int unsigned S_TDATA_W = 224;
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_TDATA_W = 328;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [NUM_TOTALS-1:0] totals_t;

    localparam word_t WORD_MAX = '1;

    typedef enum logic
    {
        CMD_BEGIN = 1'b0,
        CMD_END   = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_MAX_COST        = 3'd0,
        CFG_LAG_LIMIT       = 3'd1,
        CFG_PUBLISH_LIMIT   = 3'd2,
        CFG_DROP_LIMIT      = 3'd3,
        CFG_METER_TO_LIMIT  = 3'd4,
        CFG_METER_ERR_LIMIT = 3'd5
    } cfg_idx_t;

    localparam word_t   MAX_COST_RST = 32'd1500;
    // lowest entry is the tick-lag limit
    localparam totals_t LIMIT_RST    = {32'd5, 32'd5, 32'd5, 32'd2, 32'd3};

    // One word after both divisions, ready for the health update
    typedef struct packed {
        cmd_t    cmd;
        word_t   cost_ms;
        word_t   lag_ms;
        totals_t totals;
    } lhs_item_t;

    // One result word
    typedef struct packed {
        logic    feed_pulse;
        logic    health_ok;
        word_t   last_cost_ms;
        word_t   max_cost_ms;
        word_t   loop_total;
        word_t   fail_total;
        word_t   max_lag_ms;
        totals_t runs;
    } lhs_result_t;

endpackage

`default_nettype wire

// File: hdl/lhs_cdiv.sv
// ----------------------------------------------------------------------------
// Constant divider
// Two-stage unsigned divide by a fixed divisor: reciprocal multiply, then
// one back-multiply and a single correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module lhs_cdiv #(
    parameter int unsigned DIVISOR = lhs_pkg::TICKS_PER_MS
) (
    input  wire logic          clk,
    input  wire logic          load,
    input  wire lhs_pkg::word_t x,
    output lhs_pkg::word_t      q
);

    localparam int unsigned W       = lhs_pkg::WORD_W;
    localparam int unsigned RECIP_W = W + 1;
    localparam int unsigned PROD_W  = W + RECIP_W;
    localparam int unsigned DIV_W   = $clog2(DIVISOR + 1);
    localparam int unsigned QD_W    = W + DIV_W;

    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << W) / DIVISOR);
    localparam logic [DIV_W-1:0]   DIV_C = DIV_W'(DIVISOR);
    localparam lhs_pkg::word_t     DIV_WORD = W'(DIVISOR);

    logic [PROD_W-1:0] prod;
    lhs_pkg::word_t    x_reg;
    lhs_pkg::word_t    qest_reg;
    logic [QD_W-1:0]   qd;
    lhs_pkg::word_t    rem;

    // estimate is exact or one low
    assign prod = PROD_W'(x) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= x;
            qest_reg <= prod[2*W-1:W];
        end
    end

    assign qd  = QD_W'(qest_reg) * QD_W'(DIV_C);
    assign rem = x_reg - qd[W-1:0];
    assign q   = qest_reg + W'(rem >= DIV_WORD);

endmodule

`default_nettype wire

// File: hdl/lhs_health.sv
// ----------------------------------------------------------------------------
// Health state and evaluation
// Holds the limits, cost and change-run state; computes one result word.
// ----------------------------------------------------------------------------
`default_nettype none

module lhs_health (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [lhs_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire lhs_pkg::word_t                  cfg_wdata,
    input  wire logic                            commit,
    input  wire lhs_pkg::lhs_item_t              item,
    output lhs_pkg::lhs_result_t                 result
);

    lhs_pkg::word_t   cost_limit_reg;
    lhs_pkg::totals_t limit_reg;
    lhs_pkg::totals_t seen_reg, seen_next;
    lhs_pkg::totals_t run_reg, run_next;
    lhs_pkg::word_t   last_reg, last_next;
    lhs_pkg::word_t   max_reg, max_next;
    lhs_pkg::word_t   loop_reg, loop_next;
    lhs_pkg::word_t   fail_reg, fail_next;
    lhs_pkg::word_t   lag_reg, lag_next;
    logic             healthy;
    logic             feed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_limit_reg <= lhs_pkg::MAX_COST_RST;
            limit_reg      <= lhs_pkg::LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (lhs_pkg::cfg_idx_t'(cfg_addr))
                lhs_pkg::CFG_MAX_COST:        cost_limit_reg <= cfg_wdata;
                lhs_pkg::CFG_LAG_LIMIT:       limit_reg[0]   <= cfg_wdata;
                lhs_pkg::CFG_PUBLISH_LIMIT:   limit_reg[1]   <= cfg_wdata;
                lhs_pkg::CFG_DROP_LIMIT:      limit_reg[2]   <= cfg_wdata;
                lhs_pkg::CFG_METER_TO_LIMIT:  limit_reg[3]   <= cfg_wdata;
                lhs_pkg::CFG_METER_ERR_LIMIT: limit_reg[4]   <= cfg_wdata;
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        seen_next = seen_reg;
        run_next  = run_reg;
        last_next = last_reg;
        max_next  = max_reg;
        loop_next = loop_reg;
        lag_next  = lag_reg;
        fail_next = fail_reg;
        feed      = 1'b0;

        if (item.cmd == lhs_pkg::CMD_END)
        begin
            last_next = item.cost_ms;
            if (item.cost_ms > max_reg)
            begin
                max_next = item.cost_ms;
            end
            loop_next = loop_reg + lhs_pkg::word_t'(1);
            lag_next  = item.lag_ms;
            for (int i = 0; i < lhs_pkg::NUM_TOTALS; i++)
            begin
                if (item.totals[i] != seen_reg[i])
                begin
                    if (run_reg[i] != lhs_pkg::WORD_MAX)
                    begin
                        run_next[i] = run_reg[i] + lhs_pkg::word_t'(1);
                    end
                    seen_next[i] = item.totals[i];
                end
                else
                begin
                    run_next[i] = '0;
                end
            end
        end

        // evaluate on the state after this word
        healthy = (last_next <= cost_limit_reg);
        for (int i = 0; i < lhs_pkg::NUM_TOTALS; i++)
        begin
            if (run_next[i] >= limit_reg[i])
            begin
                healthy = 1'b0;
            end
        end

        if (item.cmd == lhs_pkg::CMD_END)
        begin
            if (healthy)
            begin
                feed = 1'b1;
            end
            else if (fail_reg != lhs_pkg::WORD_MAX)
            begin
                fail_next = fail_reg + lhs_pkg::word_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            run_reg  <= '0;
            last_reg <= '0;
            max_reg  <= '0;
            loop_reg <= '0;
            fail_reg <= '0;
            lag_reg  <= '0;
        end
        else if (commit)
        begin
            seen_reg <= seen_next;
            run_reg  <= run_next;
            last_reg <= last_next;
            max_reg  <= max_next;
            loop_reg <= loop_next;
            fail_reg <= fail_next;
            lag_reg  <= lag_next;
        end
    end

    assign result.feed_pulse   = feed;
    assign result.health_ok    = healthy;
    assign result.last_cost_ms = last_next;
    assign result.max_cost_ms  = max_next;
    assign result.loop_total   = loop_next;
    assign result.fail_total   = fail_next;
    assign result.max_lag_ms   = lag_next;
    assign result.runs         = run_next;

endmodule

`default_nettype wire

// File: hdl/loop_health_supervisor_core.sv
// ----------------------------------------------------------------------------
// Loop health supervisor core
// Measures main-loop cost, tracks error-total change runs and decides
// whether the watchdog gets fed.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the s_axis channel: tuser carries the command
//   (loop begin or loop end), tdata the tick value and the running totals.
//   Every input word produces exactly one result word on m_axis, with the
//   feed pulse, health flag, loop costs, counters and the five change runs.
//   Limits are written through cfg_we / cfg_addr / cfg_wdata while idle.
//   Each word passes, in order, the input register, tick subtract,
//   reciprocal multiply, back-multiply and correction, and the health
//   update into the result register. Throughput: one word per cycle
//   unless m_axis stalls; both constant divides are pipelined and the
//   health state is updated once per word in the last stage.
//   Reset clears all counters and stored ticks and loads the default limits.
//   When m_axis stalls, the pipeline fills up stage by stage; s_axis_tready
//   drops only once every stage holds a word.
// ----------------------------------------------------------------------------
`default_nettype none

module loop_health_supervisor_core #(
    parameter int unsigned TICKS_PER_MS = lhs_pkg::TICKS_PER_MS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // register write port
    input  wire logic                                cfg_we,
    input  wire logic [lhs_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  wire lhs_pkg::word_t                      cfg_wdata,
    // input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // now_tick, tick_lag_total, max_lag_ticks, publish_timeout_total,
    // uart_drop_total, meter_timeout_total, meter_uart_error_total
    input  wire logic [lhs_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // command
    input  wire logic [lhs_pkg::S_TUSER_W-1:0]       s_axis_tuser,
    // result stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // feed_pulse, health_ok, last_cost_ms, max_cost_ms, loop_total,
    // fail_total, max_lag_ms, lag_run, publish_run, drop_run,
    // meter_timeout_run, meter_error_run, zero pad
    output logic [lhs_pkg::M_TDATA_W-1:0]            m_axis_tdata
);

    localparam int unsigned W = lhs_pkg::WORD_W;

    // stage valids
    logic v0_reg, v1_reg, v2_reg, v3_reg, out_v_reg;
    logic rdy0, rdy1, rdy2, rdy3, out_ready;
    logic acc, adv0, adv1, adv2, adv3;

    // stage payloads
    lhs_pkg::cmd_t       cmd0_reg, cmd1_reg, cmd2_reg;
    lhs_pkg::word_t      now0_reg;
    lhs_pkg::word_t      lagt0_reg, lagt1_reg;
    lhs_pkg::totals_t    tot0_reg, tot1_reg, tot2_reg;
    lhs_pkg::word_t      elapsed1_reg;
    lhs_pkg::word_t      start_tick_reg;
    lhs_pkg::word_t      cost_q, lag_q;
    lhs_pkg::lhs_item_t  item3_reg;
    lhs_pkg::lhs_result_t result, out_reg;

    // ready ripples back from the result register; a stage takes a new
    // word when it is empty or its word moves on in the same cycle
    assign out_ready = !out_v_reg || m_axis_tready;
    assign rdy3      = !v3_reg || out_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign rdy0      = !v0_reg || rdy1;

    assign s_axis_tready = rdy0;
    assign acc           = s_axis_tvalid && rdy0;
    assign adv0          = v0_reg && rdy1;
    assign adv1          = v1_reg && rdy2;
    assign adv2          = v2_reg && rdy3;
    assign adv3          = v3_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (acc)
                v0_reg <= 1'b1;
            else if (adv0)
                v0_reg <= 1'b0;

            if (adv0)
                v1_reg <= 1'b1;
            else if (adv1)
                v1_reg <= 1'b0;

            if (adv1)
                v2_reg <= 1'b1;
            else if (adv2)
                v2_reg <= 1'b0;

            if (adv2)
                v3_reg <= 1'b1;
            else if (adv3)
                v3_reg <= 1'b0;

            if (adv3)
                out_v_reg <= 1'b1;
            else if (m_axis_tready)
                out_v_reg <= 1'b0;
        end
    end

    // input register: unpack the word
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            cmd0_reg    <= lhs_pkg::cmd_t'(s_axis_tuser[0]);
            now0_reg    <= s_axis_tdata[W-1:0];
            tot0_reg[0] <= s_axis_tdata[2*W-1:W];
            lagt0_reg   <= s_axis_tdata[3*W-1:2*W];
            tot0_reg[1] <= s_axis_tdata[4*W-1:3*W];
            tot0_reg[2] <= s_axis_tdata[5*W-1:4*W];
            tot0_reg[3] <= s_axis_tdata[6*W-1:5*W];
            tot0_reg[4] <= s_axis_tdata[7*W-1:6*W];
        end
    end

    // begin words latch the tick; end words measure from it (mod 2^32)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_tick_reg <= '0;
        end
        else if (adv0 && cmd0_reg == lhs_pkg::CMD_BEGIN)
        begin
            start_tick_reg <= now0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            cmd1_reg     <= cmd0_reg;
            elapsed1_reg <= now0_reg - start_tick_reg;
            lagt1_reg    <= lagt0_reg;
            tot1_reg     <= tot0_reg;
        end
        if (adv1)
        begin
            cmd2_reg <= cmd1_reg;
            tot2_reg <= tot1_reg;
        end
        if (adv2)
        begin
            item3_reg.cmd     <= cmd2_reg;
            item3_reg.cost_ms <= cost_q;
            item3_reg.lag_ms  <= lag_q;
            item3_reg.totals  <= tot2_reg;
        end
        if (adv3)
        begin
            out_reg <= result;
        end
    end

    // ticks to ms, for loop cost and for the largest lag
    lhs_cdiv #(
        .DIVISOR (TICKS_PER_MS)
    ) u_cost_div (
        .clk  (clk),
        .load (adv1),
        .x    (elapsed1_reg),
        .q    (cost_q)
    );

    lhs_cdiv #(
        .DIVISOR (TICKS_PER_MS)
    ) u_lag_div (
        .clk  (clk),
        .load (adv1),
        .x    (lagt1_reg),
        .q    (lag_q)
    );

    // health state advances once per word, in order
    lhs_health u_health (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .commit    (adv3),
        .item      (item3_reg),
        .result    (result)
    );

    // pack the result word, lowest field first
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {
        6'd0,
        out_reg.runs[4],
        out_reg.runs[3],
        out_reg.runs[2],
        out_reg.runs[1],
        out_reg.runs[0],
        out_reg.max_lag_ms,
        out_reg.fail_total,
        out_reg.loop_total,
        out_reg.max_cost_ms,
        out_reg.last_cost_ms,
        out_reg.health_ok,
        out_reg.feed_pulse
    };

endmodule

`default_nettype wire

// File: bench/loop_health_supervisor_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Loop health supervisor core testbench
// Streams loop begin/end words into the core, takes a hand-typed result or
// predicts one from a behavioral model of the supervisor kept in this bench,
// and compares field by field. A directed table runs first, then random
// phases under several limit settings with random idling on both sides,
// long receiver hold-offs and a full drain before every register update.
// ----------------------------------------------------------------------------

module loop_health_supervisor_core_tb;

    localparam int unsigned PIPE_LATENCY    = 6;     // core latency, plus margin
    localparam int unsigned WATCHDOG_CYCLES = 1000;  // quiet cycles before giving up
    localparam int unsigned HOLD_CYCLES     = 64;    // receiver hold-off length
    localparam int unsigned NUM_PHASES      = 8;
    localparam int unsigned PHASE_WORDS     = 205;
    localparam int unsigned IDLE_PCT        = 12;

    // register indexes beyond the implemented set; writes there are dropped
    localparam logic [lhs_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [lhs_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // One input word as the core sees it
    typedef struct packed {
        lhs_pkg::cmd_t    cmd;
        lhs_pkg::word_t   now;
        lhs_pkg::word_t   lag_ticks;
        lhs_pkg::totals_t totals;     // [0] tick lag ... [4] meter uart error
    } loop_word_t;

    // One result word, unpacked
    typedef struct packed {
        logic             feed;
        logic             ok;
        lhs_pkg::word_t   last_cost;
        lhs_pkg::word_t   max_cost;
        lhs_pkg::word_t   loops;
        lhs_pkg::word_t   fails;
        lhs_pkg::word_t   lag_ms;
        lhs_pkg::totals_t runs;
    } health_rpt_t;

    // One row of the directed table
    typedef struct {
        loop_word_t  word;
        bit          typed;  // result below is fixed by hand
        health_rpt_t want;
    } stim_row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [lhs_pkg::CFG_IDX_W-1:0]     cfg_addr;
    lhs_pkg::word_t                    cfg_wdata;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    // now_tick, tick_lag_total, max_lag_ticks, publish_timeout_total,
    // uart_drop_total, meter_timeout_total, meter_uart_error_total
    logic [lhs_pkg::S_TDATA_W-1:0]     s_axis_tdata;
    // command
    logic [lhs_pkg::S_TUSER_W-1:0]     s_axis_tuser;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    // feed_pulse, health_ok, last_cost_ms, max_cost_ms, loop_total,
    // fail_total, max_lag_ms, lag_run, publish_run, drop_run,
    // meter_timeout_run, meter_error_run, zero pad
    logic [lhs_pkg::M_TDATA_W-1:0]     m_axis_tdata;

    // Supervisor state as predicted by the bench
    lhs_pkg::word_t   cost_limit;
    lhs_pkg::totals_t run_limit;
    lhs_pkg::word_t   mark_tick;
    lhs_pkg::totals_t seen_total;
    lhs_pkg::totals_t run_len;
    lhs_pkg::word_t   cost_last;
    lhs_pkg::word_t   cost_peak;
    lhs_pkg::word_t   loop_cnt;
    lhs_pkg::word_t   fail_cnt;
    lhs_pkg::word_t   lag_ms_q;

    // Results still owed by the core, oldest first
    health_rpt_t pending_results [$];

    int unsigned mismatches;
    int unsigned begins_sent;
    int unsigned ends_sent;
    int unsigned feeds_seen;
    int unsigned fails_seen;
    int unsigned quiet_cycles;

    bit calm;       // no idling on either side while set
    bit hold_req;   // asks the receiver for one long hold-off
    int unsigned chg_pct;

    // random sequence state: where the generated loop stands
    bit               in_loop;
    lhs_pkg::word_t   gen_start;
    lhs_pkg::totals_t gen_totals;

    loop_health_supervisor_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Health on the current state: cost within limit, no run at its limit.
    // A zero run limit therefore always fails its check.
    function automatic bit loop_healthy();
        bit pass;
        pass = (cost_last <= cost_limit);
        for (int i = 0; i < lhs_pkg::NUM_TOTALS; i++)
            if (run_len[i] >= run_limit[i])
                pass = 1'b0;
        return pass;
    endfunction

    // Advance the supervisor state by one word and return the result word.
    function automatic health_rpt_t supervise_word(input loop_word_t w);
        health_rpt_t    r;
        lhs_pkg::word_t elapsed;
        r.feed = 1'b0;
        if (w.cmd == lhs_pkg::CMD_BEGIN)
        begin
            // latch the tick only; totals and lag are ignored
            mark_tick = w.now;
            r.ok = loop_healthy();
        end
        else
        begin
            elapsed   = w.now - mark_tick;   // wraps mod 2^32
            cost_last = elapsed / lhs_pkg::word_t'(lhs_pkg::TICKS_PER_MS);
            if (cost_last > cost_peak)
                cost_peak = cost_last;
            loop_cnt = loop_cnt + 1;
            lag_ms_q = w.lag_ticks / lhs_pkg::word_t'(lhs_pkg::TICKS_PER_MS);
            for (int i = 0; i < lhs_pkg::NUM_TOTALS; i++)
            begin
                if (w.totals[i] != seen_total[i])
                begin
                    if (run_len[i] != lhs_pkg::WORD_MAX)
                        run_len[i] = run_len[i] + 1;
                    seen_total[i] = w.totals[i];
                end
                else
                    run_len[i] = '0;
            end
            r.ok = loop_healthy();
            if (r.ok)
                r.feed = 1'b1;
            else if (fail_cnt != lhs_pkg::WORD_MAX)
                fail_cnt = fail_cnt + 1;
        end
        r.last_cost = cost_last;
        r.max_cost  = cost_peak;
        r.loops     = loop_cnt;
        r.fails     = fail_cnt;
        r.lag_ms    = lag_ms_q;
        r.runs      = run_len;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------

    // Offer one word, with random idle cycles ahead of it; on acceptance
    // queue its expected result (the hand-typed one where given).
    task automatic send_word(input loop_word_t w, input bit typed,
                             input health_rpt_t want);
        health_rpt_t pred;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.cmd;
        s_axis_tdata  <= {w.totals[4], w.totals[3], w.totals[2], w.totals[1],
                          w.lag_ticks, w.totals[0], w.now};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = supervise_word(w);
        pending_results.push_back(typed ? want : pred);
        if (w.cmd == lhs_pkg::CMD_BEGIN)
            begins_sent++;
        else
            ends_sent++;
    endtask

    // Stop offering and wait until every owed result has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // Write one register and mirror it in the predictor. The caller drops
    // cfg_we after the last write of a batch.
    task automatic write_reg(input logic [lhs_pkg::CFG_IDX_W-1:0] idx,
                             input lhs_pkg::word_t data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        if (idx == lhs_pkg::CFG_MAX_COST)
            cost_limit = data;
        else if (idx <= lhs_pkg::CFG_METER_ERR_LIMIT)
            run_limit[idx - 1] = data;
    endtask

    // Load one limit setting per phase, extremes among them.
    task automatic load_limits(input int unsigned phase);
        lhs_pkg::word_t   cost;
        lhs_pkg::totals_t lim;
        case (phase)
            0:
            begin
                cost = 32'd1500;
                for (int i = 0; i < lhs_pkg::NUM_TOTALS; i++)
                    lim[i] = $urandom_range(1, 4);
            end
            1:
            begin    // every check fails
                cost = '0;
                lim  = '0;
            end
            2:
            begin    // nothing can fail
                cost = lhs_pkg::WORD_MAX;
                lim  = '1;
            end
            3:
            begin
                cost = $urandom_range(500, 2500);
                for (int i = 0; i < lhs_pkg::NUM_TOTALS; i++)
                    lim[i] = $urandom_range(1, 6);
            end
            4:
            begin    // any change fails
                cost = lhs_pkg::WORD_MAX;
                for (int i = 0; i < lhs_pkg::NUM_TOTALS; i++)
                    lim[i] = 32'd1;
            end
            5:
            begin
                cost = $urandom;
                for (int i = 0; i < lhs_pkg::NUM_TOTALS; i++)
                    lim[i] = $urandom;
            end
            6:
            begin
                cost = lhs_pkg::MAX_COST_RST;
                lim  = lhs_pkg::LIMIT_RST;
            end
            default:
            begin
                cost = $urandom_range(0, 3000);
                for (int i = 0; i < lhs_pkg::NUM_TOTALS; i++)
                    lim[i] = $urandom_range(2, 5);
            end
        endcase
        write_reg(lhs_pkg::CFG_MAX_COST,        cost);
        write_reg(lhs_pkg::CFG_LAG_LIMIT,       lim[0]);
        write_reg(lhs_pkg::CFG_PUBLISH_LIMIT,   lim[1]);
        write_reg(lhs_pkg::CFG_DROP_LIMIT,      lim[2]);
        write_reg(lhs_pkg::CFG_METER_TO_LIMIT,  lim[3]);
        write_reg(lhs_pkg::CFG_METER_ERR_LIMIT, lim[4]);
        // spare indexes must not disturb any limit
        write_reg(CFG_SPARE_A, (phase == 6) ? '0 : lhs_pkg::word_t'($urandom));
        write_reg(CFG_SPARE_B, (phase == 6) ? lhs_pkg::WORD_MAX
                                            : lhs_pkg::word_t'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Build the next random word. Mostly well-formed begin/end pairs with
    // costs around the limit and totals that change in runs; the rest noise.
    task automatic random_word(output loop_word_t w);
        lhs_pkg::word_t elapsed;
        w.lag_ticks = ($urandom_range(99) < 70)
                      ? lhs_pkg::word_t'($urandom_range(0, 10 * lhs_pkg::TICKS_PER_MS))
                      : lhs_pkg::word_t'($urandom);
        if ($urandom_range(99) < 12)
        begin
            // noise: either command, unrelated ticks and totals
            w.cmd = lhs_pkg::cmd_t'($urandom_range(0, 1));
            w.now = $urandom;
            for (int i = 0; i < lhs_pkg::NUM_TOTALS; i++)
                w.totals[i] = $urandom;
            if (w.cmd == lhs_pkg::CMD_END)
                gen_totals = w.totals;
        end
        else if (!in_loop)
        begin
            w.cmd     = lhs_pkg::CMD_BEGIN;
            w.now     = $urandom;
            gen_start = w.now;
            for (int i = 0; i < lhs_pkg::NUM_TOTALS; i++)
                w.totals[i] = $urandom;
            in_loop = 1'b1;
        end
        else
        begin
            w.cmd = lhs_pkg::CMD_END;
            if ($urandom_range(99) < 10)
                elapsed = $urandom;
            else
                elapsed = lhs_pkg::word_t'($urandom_range(0, 3000))
                          * lhs_pkg::word_t'(lhs_pkg::TICKS_PER_MS)
                          + lhs_pkg::word_t'($urandom_range(0, lhs_pkg::TICKS_PER_MS - 1));
            w.now = gen_start + elapsed;
            for (int i = 0; i < lhs_pkg::NUM_TOTALS; i++)
            begin
                if ($urandom_range(99) < chg_pct)
                begin
                    if ($urandom_range(99) < 25)
                        gen_totals[i] = $urandom;
                    else
                        gen_totals[i] = gen_totals[i] + $urandom_range(1, 3);
                end
            end
            w.totals = gen_totals;
            in_loop  = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // hold off while the sender keeps offering; the core fills up
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input lhs_pkg::word_t want,
                                        input lhs_pkg::word_t got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t: %s expected %0d (0x%08h) got %0d (0x%08h)",
                         $time, name, want, want, got, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        health_rpt_t got;
        health_rpt_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.feed      = m_axis_tdata[0];
            got.ok        = m_axis_tdata[1];
            got.last_cost = m_axis_tdata[2 +: 32];
            got.max_cost  = m_axis_tdata[34 +: 32];
            got.loops     = m_axis_tdata[66 +: 32];
            got.fails     = m_axis_tdata[98 +: 32];
            got.lag_ms    = m_axis_tdata[130 +: 32];
            for (int i = 0; i < lhs_pkg::NUM_TOTALS; i++)
                got.runs[i] = m_axis_tdata[162 + 32 * i +: 32];
            if (got.feed === 1'b1)
                feeds_seen++;
            if (got.ok === 1'b0)
                fails_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: result word with none expected", $time);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("feed_pulse",   lhs_pkg::word_t'(want.feed),
                            lhs_pkg::word_t'(got.feed));
                check_field("health_ok",    lhs_pkg::word_t'(want.ok),
                            lhs_pkg::word_t'(got.ok));
                check_field("last_cost_ms", want.last_cost,     got.last_cost);
                check_field("max_cost_ms",  want.max_cost,      got.max_cost);
                check_field("loop_total",   want.loops,         got.loops);
                check_field("fail_total",   want.fails,         got.fails);
                check_field("max_lag_ms",   want.lag_ms,        got.lag_ms);
                for (int i = 0; i < lhs_pkg::NUM_TOTALS; i++)
                    check_field($sformatf("change run %0d", i), want.runs[i], got.runs[i]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: give up after too many cycles with no word moving
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : stall_watch
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_CYCLES)
        begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_CYCLES);
            $display("** loop_health_supervisor_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t   rows [$];
        stim_row_t   row;
        loop_word_t  w;
        health_rpt_t none;

        // known levels on every input from time zero
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        quiet_cycles  = 0;
        mismatches    = 0;
        begins_sent   = 0;
        ends_sent     = 0;
        feeds_seen    = 0;
        fails_seen    = 0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        chg_pct       = 50;
        in_loop       = 1'b0;
        gen_start     = '0;
        gen_totals    = '0;
        none          = '0;

        // predictor starts from the reset state
        cost_limit = lhs_pkg::MAX_COST_RST;
        run_limit  = lhs_pkg::LIMIT_RST;
        mark_tick  = '0;
        seen_total = '0;
        run_len    = '0;
        cost_last  = '0;
        cost_peak  = '0;
        loop_cnt   = '0;
        fail_cnt   = '0;
        lag_ms_q   = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed table, default limits ---
        row.typed = 1'b0;
        row.want  = '0;
        // end with no begin: cost measured from the cleared start tick
        row.word = '{lhs_pkg::CMD_END, 32'd360000, 32'd504000, '0};
        row.typed = 1'b1;
        row.want  = '{feed: 1'b1, ok: 1'b1, last_cost: 32'd5, max_cost: 32'd5, loops: 32'd1,
                      fails: 32'd0, lag_ms: 32'd7, runs: '0};
        rows.push_back(row);
        // begin: only the tick moves, totals and lag ignored
        row.word = '{lhs_pkg::CMD_BEGIN, 32'd1000, lhs_pkg::WORD_MAX, '1};
        row.want.feed = 1'b0;
        rows.push_back(row);
        row.typed = 1'b0;
        // repeated begin keeps the latest tick, then the tick wraps
        row.word = '{lhs_pkg::CMD_BEGIN, 32'hFFFF_0000, 32'd0, '0};
        rows.push_back(row);
        row.word = '{lhs_pkg::CMD_END, 32'h0001_2000, 32'd0,
                     {32'd0, 32'd0, 32'd0, 32'd0, 32'd1}};
        rows.push_back(row);
        // largest cost and lag, all totals at their top value
        row.word = '{lhs_pkg::CMD_BEGIN, 32'd0, 32'd0, '0};
        rows.push_back(row);
        row.word = '{lhs_pkg::CMD_END, lhs_pkg::WORD_MAX, lhs_pkg::WORD_MAX, '1};
        rows.push_back(row);
        // cost exactly at the limit, totals unchanged so runs clear
        row.word = '{lhs_pkg::CMD_BEGIN, 32'd0, 32'd0, '0};
        rows.push_back(row);
        row.word = '{lhs_pkg::CMD_END, 32'd108071999, 32'd0, '1};
        rows.push_back(row);
        // one ms over the limit
        row.word = '{lhs_pkg::CMD_END, 32'd108072000, 32'd71999, '1};
        rows.push_back(row);
        // every total changes five loops running: runs climb to their limits
        for (int k = 1; k <= 5; k++)
        begin
            row.word = '{lhs_pkg::CMD_END, lhs_pkg::word_t'(k * lhs_pkg::TICKS_PER_MS),
                         32'd72000, {lhs_pkg::NUM_TOTALS{lhs_pkg::word_t'(k)}}};
            rows.push_back(row);
        end
        // unchanged totals clear every run; zero cost
        row.word = '{lhs_pkg::CMD_END, 32'd0, 32'd0, {lhs_pkg::NUM_TOTALS{32'd5}}};
        rows.push_back(row);
        row.word = '{lhs_pkg::CMD_END, 32'd0, 32'd0, '0};
        rows.push_back(row);

        foreach (rows[i])
            send_word(rows[i].word, rows[i].typed, rows[i].want);

        // --- random phases, one limit setting each ---
        gen_totals = seen_total;
        for (int unsigned phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            load_limits(phase);
            calm    = (phase == 3);
            chg_pct = (phase == 4) ? 20 : (phase == 7) ? 70 : 50;
            for (int unsigned n = 0; n < PHASE_WORDS; n++)
            begin
                if (n == 100 && (phase == 2 || phase == 5))
                    hold_req = 1'b1;
                if (n == 100 && phase == 4)
                    drain();    // sender pause until the core is empty
                random_word(w);
                send_word(w, 1'b0, none);
            end
        end

        drain();
        mismatches += pending_results.size();

        $display("covered %0d words: %0d loop begins, %0d loop ends, %0d limit settings",
                 begins_sent + ends_sent, begins_sent, ends_sent, NUM_PHASES + 1);
        $display("results: %0d watchdog feeds, %0d unhealthy words, %0d mismatches",
                 feeds_seen, fails_seen, mismatches);
        if (mismatches == 0)
            $display("** loop_health_supervisor_core: PASSED **");
        else
            $display("** loop_health_supervisor_core: FAILED **");
        $finish;
    end

endmodule

// File: files.f
hdl/lhs_pkg.sv
hdl/lhs_cdiv.sv
hdl/lhs_health.sv
hdl/loop_health_supervisor_core.sv
bench/loop_health_supervisor_core_tb.sv
